@@ rtl/core/ega_text_mode_pixel_generator_defines.svh @@
// Assertion macros shared by the checker of the EGA text-mode pixel generator.
// Depends on nothing; the including module must provide clk and rst.
`ifndef EGA_TEXT_MODE_PIXEL_GENERATOR_DEFINES_SVH
`define EGA_TEXT_MODE_PIXEL_GENERATOR_DEFINES_SVH

// Property checked at every edge, reset included.
`define EGATP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("check failed: label");

// Property checked outside reset.
`define EGATP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("check failed: label");

`endif

@@ rtl/core/egatp_pkg.sv @@
// Shared types, constants and helper functions of the EGA text-mode pixel generator.
// Depends on nothing; all other files but the defines header use it by scoped names.
package egatp_pkg;

  localparam int TEXT_COLS   = 80;
  localparam int TEXT_ROWS   = 25;
  localparam int CELL_WIDTH  = 8;
  localparam int CELL_HEIGHT = 14;
  localparam int FONT_STRIDE = 32;
  localparam int OFFSET_BITS = 16;

  localparam int SCREEN_W = TEXT_COLS * CELL_WIDTH;
  localparam int SCREEN_H = TEXT_ROWS * CELL_HEIGHT;

  localparam int X_W       = 10;
  localparam int Y_W       = 9;
  localparam int COL_W     = $clog2(TEXT_COLS);
  localparam int BIT_W     = $clog2(CELL_WIDTH);
  localparam int LINE_W    = $clog2(CELL_HEIGHT);
  localparam int FONT_SH   = $clog2(FONT_STRIDE);
  localparam int FONT_AW   = 8 + FONT_SH;
  localparam int TEXT_AW   = OFFSET_BITS;
  localparam int WORD_W    = 16;
  localparam int PAL_AW    = 4;
  localparam int PAL_W     = 6;
  localparam int CHAN_W    = 8;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);

  typedef enum logic [1:0] {
    KIND_TEXT_WR = 2'd0,
    KIND_FONT_WR = 2'd1,
    KIND_PAL_WR  = 2'd2,
    KIND_TICK    = 2'd3
  } kind_t;

  // One queued operation: a store write, or a pixel tick with its cell address
  // already resolved in the addr field.
  typedef struct packed {
    kind_t               kind;
    logic [WORD_W-1:0]   addr;
    logic [WORD_W-1:0]   data;
    logic [X_W-1:0]      x;
    logic [Y_W-1:0]      y;
    logic [LINE_W-1:0]   line;
    logic                last;
  } entry_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  // Primary weighs 0xAA and secondary 0x55; the two never overlap, so the sum
  // is just the interleaved bit pattern.
  function automatic logic [CHAN_W-1:0] chan_level(input logic pri, input logic sec);
    chan_level = {pri, sec, pri, sec, pri, sec, pri, sec};
  endfunction

endpackage

@@ rtl/core/ega_text_mode_pixel_generator.sv @@
// EGA text-mode pixel generator: an 80x25 text screen of 8x14 cells turned into
// a stream of RGB pixels in raster order. Every input transfer is either a write
// to one of the three stores (kind 0: character and attribute word, kind 1: font
// byte at char*32+line, kind 2: 6-bit palette entry) or a pixel tick (kind 3),
// and every tick yields exactly one output transfer; writes yield none. Items
// are handled strictly in order, so a write is seen by every later tick. The
// block takes one item per clock and delivers one pixel per clock at full rate;
// a tick passes through the queue slot, the text word read, the glyph byte read
// and the output register, which also takes the palette lookup. A four-entry
// queue sits between the input side and the store pipeline, so input transfers
// continue while the output is held off, until the queue fills. After reset the
// block runs a clearing pass over every text store address that zeroes the text
// and font stores; in_ready stays low until it is done. The display start
// register (cfg_we, cfg_data) may be written only while the block is idle; it
// takes effect for ticks accepted afterward.
// Depends on egatp_pkg, egatp_front, egatp_queue and egatp_back.
module ega_text_mode_pixel_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [15:0] addr,
  input  logic [15:0] data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  pixel_x,
  output logic [8:0]  pixel_y,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic        end_of_frame
);

  logic [15:0]               disp_start;
  logic                      push;
  egatp_pkg::entry_t         push_entry;
  logic                      pop;
  egatp_pkg::entry_t         pop_entry;
  logic                      q_empty;
  logic                      q_full;
  egatp_pkg::back_status_t   status;

  // Display start register, written directly from the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      disp_start <= '0;
    end else if (cfg_we) begin
      disp_start <= cfg_data;
    end
  end

  // The front end classifies each transfer and, for ticks, resolves the text
  // cell address from the raster position and the display start.
  egatp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .addr         (addr),
    .data         (data),
    .disp_start   (disp_start),
    .q_full       (q_full),
    .status       (status),
    .push         (push),
    .push_entry   (push_entry)
  );

  egatp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty),
    .full       (q_full)
  );

  // The back end performs the store writes and the three lookups of a tick.
  egatp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_entry      (pop_entry),
    .q_empty      (q_empty),
    .pop          (pop),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .end_of_frame (end_of_frame)
  );

endmodule

@@ rtl/core/egatp_front.sv @@
// Front end: accepts input transfers, tracks the raster and resolves cell addresses.
// Depends on egatp_pkg.
module egatp_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    kind,
  input  logic [15:0]                   addr,
  input  logic [15:0]                   data,
  input  logic [15:0]                   disp_start,
  input  logic                          q_full,
  input  egatp_pkg::back_status_t       status,
  output logic                          push,
  output egatp_pkg::entry_t             push_entry
);

  logic [egatp_pkg::X_W-1:0]       raster_x;
  logic [egatp_pkg::Y_W-1:0]       raster_y;
  logic [egatp_pkg::COL_W-1:0]     col;
  logic [egatp_pkg::LINE_W-1:0]    line;
  logic [egatp_pkg::TEXT_AW-1:0]   row_base;
  logic                            x_last;
  logic                            y_last;
  logic                            bit_last;
  logic                            line_last;
  logic                            tick;
  logic [egatp_pkg::TEXT_AW-1:0]   cell_addr;

  assign in_ready  = !q_full && !status.clearing;
  assign push      = in_valid && in_ready;
  assign tick      = push && (egatp_pkg::kind_t'(kind) == egatp_pkg::KIND_TICK);

  assign x_last    = raster_x == egatp_pkg::X_W'(egatp_pkg::SCREEN_W - 1);
  assign y_last    = raster_y == egatp_pkg::Y_W'(egatp_pkg::SCREEN_H - 1);
  assign bit_last  = raster_x[egatp_pkg::BIT_W-1:0] == egatp_pkg::BIT_W'(egatp_pkg::CELL_WIDTH - 1);
  assign line_last = line == egatp_pkg::LINE_W'(egatp_pkg::CELL_HEIGHT - 1);

  assign cell_addr = disp_start + row_base + egatp_pkg::TEXT_AW'(col);

  always_comb begin
    push_entry      = '0;
    push_entry.kind = egatp_pkg::kind_t'(kind);
    push_entry.addr = addr;
    push_entry.data = data;
    push_entry.x    = raster_x;
    push_entry.y    = raster_y;
    push_entry.line = line;
    push_entry.last = x_last && y_last;
    if (egatp_pkg::kind_t'(kind) == egatp_pkg::KIND_TICK) begin
      push_entry.addr = cell_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raster_x <= '0;
      raster_y <= '0;
      col      <= '0;
      line     <= '0;
      row_base <= '0;
    end else if (tick) begin
      if (x_last) begin
        raster_x <= '0;
        col      <= '0;
        if (y_last) begin
          raster_y <= '0;
          line     <= '0;
          row_base <= '0;
        end else begin
          raster_y <= raster_y + 1'b1;
          if (line_last) begin
            line     <= '0;
            row_base <= row_base + egatp_pkg::TEXT_AW'(egatp_pkg::TEXT_COLS);
          end else begin
            line <= line + 1'b1;
          end
        end
      end else begin
        raster_x <= raster_x + 1'b1;
        if (bit_last) begin
          col <= col + 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/core/egatp_queue.sv @@
// Short register queue between the front end and the pixel pipeline.
// Depends on egatp_pkg.
module egatp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  egatp_pkg::entry_t   push_entry,
  input  logic                pop,
  output egatp_pkg::entry_t   pop_entry,
  output logic                empty,
  output logic                full
);

  egatp_pkg::entry_t                 slots [egatp_pkg::Q_DEPTH];
  logic [egatp_pkg::Q_PTR_W-1:0]     wr_ptr;
  logic [egatp_pkg::Q_PTR_W-1:0]     rd_ptr;
  logic [egatp_pkg::Q_PTR_W:0]       count;

  assign empty     = count == '0;
  assign full      = count == (egatp_pkg::Q_PTR_W + 1)'(egatp_pkg::Q_DEPTH);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/egatp_back.sv @@
// Back end: text, font and palette stores in a pipeline that ends in the output register.
// Depends on egatp_pkg.
module egatp_back (
  input  logic                                clk,
  input  logic                                rst,
  input  egatp_pkg::entry_t                   q_entry,
  input  logic                                q_empty,
  output logic                                pop,
  output egatp_pkg::back_status_t             status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [egatp_pkg::X_W-1:0]           pixel_x,
  output logic [egatp_pkg::Y_W-1:0]           pixel_y,
  output logic [egatp_pkg::CHAN_W-1:0]        red,
  output logic [egatp_pkg::CHAN_W-1:0]        green,
  output logic [egatp_pkg::CHAN_W-1:0]        blue,
  output logic                                end_of_frame
);

  logic [egatp_pkg::WORD_W-1:0]   text_mem [2**egatp_pkg::TEXT_AW];
  logic [7:0]                     font_mem [2**egatp_pkg::FONT_AW];
  logic [egatp_pkg::PAL_W-1:0]    pal      [2**egatp_pkg::PAL_AW];

  logic                           clr_active;
  logic [egatp_pkg::TEXT_AW-1:0]  clr_cnt;

  logic                           adv;
  logic                           s1_valid;
  egatp_pkg::entry_t              s1_e;
  logic [egatp_pkg::WORD_W-1:0]   text_rd;
  logic                           s2_valid;
  egatp_pkg::entry_t              s2_e;
  logic [7:0]                     s2_attr;
  logic [7:0]                     font_rd;
  logic [egatp_pkg::FONT_AW-1:0]  glyph_addr;
  logic [egatp_pkg::BIT_W-1:0]    bit_pos;
  logic                           fg;
  logic [egatp_pkg::PAL_AW-1:0]   pal_idx;
  logic [egatp_pkg::PAL_W-1:0]    pal_val;

  // The whole pipeline moves together whenever the output register can take a value.
  assign adv             = !out_valid || out_ready;
  assign pop             = adv && !q_empty;
  assign status.clearing = clr_active;

  // Clearing pass over both large stores after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_cnt    <= '0;
    end else if (clr_active) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == '1) begin
        clr_active <= 1'b0;
      end
    end
  end

  // Stage 1: text store.
  always_ff @(posedge clk) begin
    if (clr_active) begin
      text_mem[clr_cnt] <= '0;
    end else if (pop && q_entry.kind == egatp_pkg::KIND_TEXT_WR) begin
      text_mem[q_entry.addr] <= q_entry.data;
    end
    if (adv) begin
      text_rd <= text_mem[q_entry.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_e <= q_entry;
    end
  end

  // Stage 2: font store, addressed by character and glyph line.
  assign glyph_addr = (egatp_pkg::FONT_AW'(text_rd[7:0]) << egatp_pkg::FONT_SH)
                    + egatp_pkg::FONT_AW'(s1_e.line);

  always_ff @(posedge clk) begin
    if (clr_active) begin
      font_mem[clr_cnt[egatp_pkg::FONT_AW-1:0]] <= '0;
    end else if (adv && s1_valid && s1_e.kind == egatp_pkg::KIND_FONT_WR) begin
      font_mem[s1_e.addr[egatp_pkg::FONT_AW-1:0]] <= s1_e.data[7:0];
    end
    if (adv) begin
      font_rd <= font_mem[glyph_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_e    <= s1_e;
      s2_attr <= text_rd[15:8];
    end
  end

  // Stage 3: pick the glyph bit, look up the palette, expand to RGB.
  assign bit_pos = egatp_pkg::BIT_W'(egatp_pkg::CELL_WIDTH - 1) - s2_e.x[egatp_pkg::BIT_W-1:0];
  assign fg      = font_rd[bit_pos];
  assign pal_idx = fg ? s2_attr[3:0] : {1'b0, s2_attr[6:4]};
  assign pal_val = pal[pal_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2**egatp_pkg::PAL_AW; i++) begin
        pal[i] <= '0;
      end
    end else if (adv && s2_valid && s2_e.kind == egatp_pkg::KIND_PAL_WR) begin
      pal[s2_e.addr[egatp_pkg::PAL_AW-1:0]] <= s2_e.data[egatp_pkg::PAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_valid && s2_e.kind == egatp_pkg::KIND_TICK;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel_x      <= s2_e.x;
      pixel_y      <= s2_e.y;
      end_of_frame <= s2_e.last;
      red          <= egatp_pkg::chan_level(pal_val[2], pal_val[5]);
      green        <= egatp_pkg::chan_level(pal_val[1], pal_val[4]);
      blue         <= egatp_pkg::chan_level(pal_val[0], pal_val[3]);
    end
  end

endmodule

@@ rtl/core/egatp_checker.sv @@
// Port-level checker for the EGA text-mode pixel generator, bound to the top level.
// Depends on egatp_pkg and ega_text_mode_pixel_generator_defines.svh.
`include "ega_text_mode_pixel_generator_defines.svh"

module egatp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [9:0]  pixel_x,
  input logic [8:0]  pixel_y,
  input logic        end_of_frame
);

  // The store clearing pass holds off input and output right after reset.
  `EGATP_ASSERT_ALWAYS(a_reset_quiet, rst |=> !in_ready && !out_valid)

  // A held pixel stays offered until it is taken.
  `EGATP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(pixel_x))

  // The frame marker only rides on the bottom right pixel.
  `EGATP_ASSERT(a_eof_pos, out_valid && end_of_frame |->
                pixel_x == 10'(egatp_pkg::SCREEN_W - 1) &&
                pixel_y == 9'(egatp_pkg::SCREEN_H - 1))

  // Pixel coordinates never leave the screen.
  `EGATP_ASSERT(a_pos_range, out_valid |->
                pixel_x < 10'(egatp_pkg::SCREEN_W) && pixel_y < 9'(egatp_pkg::SCREEN_H))

endmodule

bind ega_text_mode_pixel_generator egatp_checker u_checker (.*);

@@ bench/ega_text_mode_pixel_generator_tb.sv @@
// Self-checking testbench for the EGA text-mode pixel generator.
// It needs egatp_pkg and the ega_text_mode_pixel_generator RTL, and nothing else.
`timescale 1ns / 1ps

module ega_text_mode_pixel_generator_tb;

  // The font store wraps at 256 glyphs of FONT_STRIDE rows each.
  localparam int FONT_DEPTH = 256 * egatp_pkg::FONT_STRIDE;
  // Cycles the receiver holds off in one long stretch. This is far more than
  // the queue and the store pipeline can absorb.
  localparam int LONG_HOLD = 300;
  // Cycles allowed after the last pixel for writes still in the store pipeline.
  localparam int SETTLE = 16;

  typedef struct packed {
    logic [9:0] x;
    logic [8:0] y;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       eof;
  } pixel_t;

  // An expected pixel, together with the time at which its tick was accepted.
  typedef struct {
    pixel_t px;
    longint at;
  } due_pixel_t;

  // Screen model: the three stores, the raster position and the start offset.
  // It renders the pixel of every accepted tick and checks the pixels that come out.
  class ega_screen_model;
    logic [15:0] text_mem [65536];
    logic [7:0]  font_mem [FONT_DEPTH];
    logic [5:0]  pal_mem  [16];
    logic [9:0]  ras_x;
    logic [8:0]  ras_y;
    logic [15:0] start_cell;
    due_pixel_t  pixels_due [$];
    int          errors;

    function new();
      foreach (text_mem[i]) text_mem[i] = '0;
      foreach (font_mem[i]) font_mem[i] = '0;
      foreach (pal_mem[i]) pal_mem[i] = '0;
      ras_x = '0;
      ras_y = '0;
      start_cell = '0;
      errors = 0;
    endfunction

    // The text cell shown at a screen position. It wraps at 64K cells.
    function logic [15:0] cell_at(int px, int py);
      int sum;
      sum = start_cell + (py / egatp_pkg::CELL_HEIGHT) * egatp_pkg::TEXT_COLS
            + px / egatp_pkg::CELL_WIDTH;
      return sum[15:0];
    endfunction

    function logic [7:0] level(logic pri, logic sec);
      return (pri ? 8'hAA : 8'h00) + (sec ? 8'h55 : 8'h00);
    endfunction

    function pixel_t render_tick();
      pixel_t      p;
      logic [15:0] word;
      logic [7:0]  glyph;
      logic [3:0]  idx;
      logic [5:0]  pal;
      int          bitpos;
      int          line;
      bitpos = ras_x % egatp_pkg::CELL_WIDTH;
      line = ras_y % egatp_pkg::CELL_HEIGHT;
      word = text_mem[cell_at(ras_x, ras_y)];
      glyph = font_mem[(int'(word[7:0]) * egatp_pkg::FONT_STRIDE + line) % FONT_DEPTH];
      // A lit glyph bit takes the foreground entry. A dark bit takes the
      // background entry, and the blink bit plays no part in it.
      idx = glyph[7 - bitpos] ? word[11:8] : {1'b0, word[14:12]};
      pal = pal_mem[idx];
      p.x = ras_x;
      p.y = ras_y;
      p.r = level(pal[2], pal[5]);
      p.g = level(pal[1], pal[4]);
      p.b = level(pal[0], pal[3]);
      p.eof = (ras_x == egatp_pkg::SCREEN_W - 1) && (ras_y == egatp_pkg::SCREEN_H - 1);
      if (ras_x == egatp_pkg::SCREEN_W - 1) begin
        ras_x = '0;
        ras_y = (ras_y == egatp_pkg::SCREEN_H - 1) ? '0 : ras_y + 1'b1;
      end else begin
        ras_x = ras_x + 1'b1;
      end
      return p;
    endfunction

    function void take_item(egatp_pkg::kind_t k, logic [15:0] a, logic [15:0] d);
      due_pixel_t due;
      case (k)
        egatp_pkg::KIND_TEXT_WR: text_mem[a] = d;
        egatp_pkg::KIND_FONT_WR: font_mem[int'(a) % FONT_DEPTH] = d[7:0];
        egatp_pkg::KIND_PAL_WR:  pal_mem[a[3:0]] = d[5:0];
        default: begin
          due.px = render_tick();
          due.at = $time;
          pixels_due.push_back(due);
        end
      endcase
    endfunction

    function void compare(string name, pixel_t want, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: pixel (%0d,%0d) %s expected %h got %h",
                 $time, want.x, want.y, name, exp_v, act_v);
        errors++;
      end
    endfunction

    // A tick accepted at this very edge cannot have its pixel out yet, so it
    // does not count as waiting. The order of events within the step does not matter.
    function void check_pixel(pixel_t got);
      pixel_t     want;
      due_pixel_t head;
      if (pixels_due.size() == 0 || pixels_due[0].at == $time) begin
        $display("%0t: unexpected pixel (%0d,%0d) expected none", $time, got.x, got.y);
        errors++;
        return;
      end
      head = pixels_due.pop_front();
      want = head.px;
      compare("pixel_x", want, want.x, got.x);
      compare("pixel_y", want, want.y, got.y);
      compare("red", want, want.r, got.r);
      compare("green", want, want.g, got.g);
      compare("blue", want, want.b, got.b);
      compare("end_of_frame", want, want.eof, got.eof);
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [15:0]       cfg_data;
  logic              in_valid;
  logic              in_ready;
  egatp_pkg::kind_t  kind;
  logic [15:0]       addr;
  logic [15:0]       data;
  logic              out_valid;
  logic              out_ready;
  logic [9:0]        pixel_x;
  logic [8:0]        pixel_y;
  logic [7:0]        red;
  logic [7:0]        green;
  logic [7:0]        blue;
  logic              end_of_frame;

  ega_screen_model model;

  // Idle rates in percent for the sender and the receiver, changed per phase.
  int send_idle_pct;
  int stall_pct;
  // Raised by the stimulus to ask the receiver for one long hold-off.
  bit long_hold_req;

  ega_text_mode_pixel_generator u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .addr         (addr),
    .data         (data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .end_of_frame (end_of_frame)
  );

  always #5 clk = ~clk;

  // Output monitor. Every pixel transfer is checked against the oldest
  // expectation. The values sampled at the rising edge are those from before it.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      model.check_pixel({pixel_x, pixel_y, red, green, blue, end_of_frame});
    end
  end

  // Receiver. It changes out_ready on the falling edge only. A long hold-off
  // counts its own cycles here while the sender keeps offering items. The
  // block must then fill its queue and drop in_ready.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offers one item, with random idle cycles before it, and returns at the
  // rising edge of its transfer. The model takes the item in this same process,
  // so the raster position seen by the next burst is already up to date.
  task automatic send_item(egatp_pkg::kind_t k, logic [15:0] a, logic [15:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    kind <= k;
    addr <= a;
    data <= d;
    do @(posedge clk); while (!in_ready);
    model.take_item(k, a, d);
  endtask

  // A tick ignores addr and data, so those carry random values.
  task automatic send_tick();
    send_item(egatp_pkg::KIND_TICK, 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)));
  endtask

  // Stops offering items and waits until every expected pixel has arrived.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (model.pixels_due.size() != 0) @(posedge clk);
  endtask

  // The start offset is written only while the block is idle. Writes that
  // came after the last tick may still be in the store pipeline, so a few
  // cycles pass first.
  task automatic write_start(logic [15:0] v);
    drain();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    model.start_cell = v;
  endtask

  // Random traffic, mostly in bursts that make the next pixels worth looking at.
  // Each burst writes the text cells under the raster, writes the glyph row
  // that those cells will show and maybe one palette entry, and then ticks
  // across them. The rest are single items of any kind with random fields.
  task automatic run_bursts(int n);
    int          sent;
    int          px;
    int          run;
    logic [15:0] cell_addr;
    logic [15:0] word;
    logic [15:0] faddr;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 75) begin
        for (int k = 0; k < 3; k++) begin
          px = model.ras_x + k * egatp_pkg::CELL_WIDTH;
          if (px < egatp_pkg::SCREEN_W) begin
            cell_addr = model.cell_at(px, model.ras_y);
            word = 16'($urandom_range(0, 65535));
            send_item(egatp_pkg::KIND_TEXT_WR, cell_addr, word);
            // The high address bits beyond the font store are random, so the
            // write reaches the same glyph row through the wrap.
            faddr = 16'(int'(word[7:0]) * egatp_pkg::FONT_STRIDE
                        + int'(model.ras_y) % egatp_pkg::CELL_HEIGHT
                        + $urandom_range(0, 7) * FONT_DEPTH);
            send_item(egatp_pkg::KIND_FONT_WR, faddr, 16'($urandom_range(0, 65535)));
            sent += 2;
          end
        end
        if ($urandom_range(1)) begin
          send_item(egatp_pkg::KIND_PAL_WR, 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)));
          sent++;
        end
        run = $urandom_range(4, 40);
        repeat (run) send_tick();
        sent += run;
      end else begin
        send_item(egatp_pkg::kind_t'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)));
        sent++;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    kind = egatp_pkg::KIND_TEXT_WR;
    addr = '0;
    data = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    long_hold_req = 1'b0;
    model = new();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. The block sits in its clearing pass first, and in_ready
    // holds the first transfer back until that pass is over.
    write_start(16'h0000);
    // All stores are still zero, so the origin pixel is black.
    send_item(egatp_pkg::KIND_TICK, 16'hFFFF, 16'hFFFF);
    // Only the low four address bits and the low six data bits reach the palette.
    send_item(egatp_pkg::KIND_PAL_WR, 16'hFFFF, 16'hFFFF);
    send_item(egatp_pkg::KIND_PAL_WR, 16'h0007, 16'h0015);
    send_item(egatp_pkg::KIND_PAL_WR, 16'h0000, 16'h0000);
    // Cell 1 gets character FF with attribute FF: foreground 15 and
    // background 7, since the blink bit is dropped.
    send_item(egatp_pkg::KIND_TEXT_WR, 16'h0001, 16'hFFFF);
    send_item(egatp_pkg::KIND_TEXT_WR, 16'h0000, 16'h0000);
    // This address lies beyond the font store and wraps onto row 0 of glyph FF.
    // The byte keeps only its low eight bits.
    send_item(egatp_pkg::KIND_FONT_WR, 16'hFFE0, 16'hFF5A);
    send_item(egatp_pkg::KIND_FONT_WR, 16'h0000, 16'h0000);
    // These ticks run through the rest of cell 0 and across the whole glyph
    // row of cell 1. The writes above take effect at once.
    repeat (7) send_item(egatp_pkg::KIND_TICK, 16'h0000, 16'h0000);
    repeat (8) send_item(egatp_pkg::KIND_TICK, 16'hFFFF, 16'hFFFF);

    // The start offset is at its top, so the cell sum wraps. No idling here.
    write_start(16'hFFFF);
    run_bursts(400);

    // The sender idles often.
    send_idle_pct = 57;
    write_start(16'($urandom_range(0, 65535)));
    run_bursts(400);

    // The receiver stalls often. One long hold-off comes early and fills the block.
    send_idle_pct = 0;
    stall_pct = 57;
    write_start(16'($urandom_range(0, 65535)));
    send_tick();
    long_hold_req = 1'b1;
    run_bursts(400);

    // Both sides idle. The sender pauses halfway until everything is out.
    send_idle_pct = 29;
    stall_pct = 29;
    write_start(16'($urandom_range(0, 65535)));
    run_bursts(200);
    drain();
    run_bursts(200);

    // A short full-rate run of ticks with the start offset back at zero.
    send_idle_pct = 0;
    stall_pct = 0;
    write_start(16'h0000);
    repeat (egatp_pkg::SCREEN_W / 16) send_tick();

    drain();
    repeat (SETTLE) @(posedge clk);
    if (model.errors == 0) begin
      $display("ega_text_mode_pixel_generator regression: pass");
    end else begin
      $display("ega_text_mode_pixel_generator regression: fail");
    end
    $finish;
  end

  // Guard against a hung run. The budget covers the clearing pass and the
  // stalled phases many times over.
  initial begin
    #30_000_000;
    $display("ega_text_mode_pixel_generator regression: fail");
    $finish;
  end

endmodule
